>>> rtl/rart_pkg.sv
// ----------------------------------------------------------------------------
// rart_pkg: shared constants and types for the rotary angle rate tracker
// Register map, reference scaling of the unwrap limit and reset values.
// ----------------------------------------------------------------------------
package rart_pkg;

   // Register index port width; indexes past the map are ignored
   localparam int CSR_INDEX_BITS = 8;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_MOUNT_OFFSET = csr_index_type'(0);
   localparam csr_index_type CSR_USER_OFFSET  = csr_index_type'(1);

   // Mount offset after reset, taken modulo one turn
   localparam int MOUNT_OFFSET_RESET = 401;

   // Unwrap limit is 2000 counts for a 12-bit turn and scales with the turn
   localparam int UNWRAP_LIMIT_REF = 2000;
   localparam int REF_ANGLE_BITS   = 12;

endpackage

>>> rtl/rart_wrap.sv
// ----------------------------------------------------------------------------
// rart_wrap: offset adder
// Adds the mount and user offsets to a raw angle and wraps into one turn.
// ----------------------------------------------------------------------------
module rart_wrap #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                         [ANGLE_BITS-1:0] raw_angle,
   input  logic signed                  [ANGLE_BITS-1:0] mount_offset,
   input  logic signed                  [ANGLE_BITS-1:0] user_offset,
   output logic                         [ANGLE_BITS-1:0] angle
);

   logic signed [ANGLE_BITS+1:0] sum_w;

   assign sum_w = $signed({2'b00, raw_angle})
                + $signed({{2{mount_offset[ANGLE_BITS-1]}}, mount_offset})
                + $signed({{2{user_offset[ANGLE_BITS-1]}}, user_offset});

   // sum lies within one turn either side of the range, so the low bits
   // are exactly the single add or subtract of a turn
   assign angle = sum_w[ANGLE_BITS-1:0];

endmodule

>>> rtl/rart_rate.sv
// ----------------------------------------------------------------------------
// rart_rate: velocity and acceleration unit
// Holds the previous angle and two velocities; unwraps and differentiates.
// ----------------------------------------------------------------------------
module rart_rate import rart_pkg::*; #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic        [ANGLE_BITS-1:0] angle,
   output logic signed [ANGLE_BITS:0]   velocity,
   output logic signed [ANGLE_BITS:0]   acceleration
);

   localparam int Turn  = 1 << ANGLE_BITS;
   localparam int Limit = (UNWRAP_LIMIT_REF << ANGLE_BITS) >> REF_ANGLE_BITS;
   localparam int Bound = (Limit > Turn - Limit - 1) ? Limit : Turn - Limit - 1;
   localparam logic signed [ANGLE_BITS+1:0] LimitV = (ANGLE_BITS+2)'(Limit);
   localparam logic signed [ANGLE_BITS+1:0] TurnV  = (ANGLE_BITS+2)'(Turn);
   localparam logic signed [ANGLE_BITS+1:0] BoundV = (ANGLE_BITS+2)'(Bound);

   logic        [ANGLE_BITS-1:0] prev_angle_ff, prev_angle_in;
   logic signed [ANGLE_BITS:0]   hist0_ff, hist0_in;
   logic signed [ANGLE_BITS:0]   hist1_ff, hist1_in;

   logic signed [ANGLE_BITS+1:0] diff_w;
   logic signed [ANGLE_BITS+1:0] vel_w;
   logic signed [ANGLE_BITS+1:0] dacc_w;
   logic signed [ANGLE_BITS+1:0] rnd_w;
   logic signed [ANGLE_BITS+1:0] half_w;

   always_comb begin
      diff_w = $signed({2'b00, angle}) - $signed({2'b00, prev_angle_ff});
      if (diff_w > LimitV) begin
         vel_w = diff_w - TurnV;
      end else if (diff_w < -LimitV) begin
         vel_w = diff_w + TurnV;
      end else begin
         vel_w = diff_w;
      end
      dacc_w = vel_w - $signed({hist1_ff[ANGLE_BITS], hist1_ff});
      // bias negatives by one so the shift truncates toward zero
      rnd_w  = dacc_w + $signed({{(ANGLE_BITS+1){1'b0}}, dacc_w[ANGLE_BITS+1]});
      half_w = rnd_w >>> 1;
   end

   assign velocity     = vel_w[ANGLE_BITS:0];
   assign acceleration = half_w[ANGLE_BITS:0];

   always_comb begin
      prev_angle_in = prev_angle_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      if (advance) begin
         prev_angle_in = angle;
         hist0_in      = vel_w[ANGLE_BITS:0];
         hist1_in      = hist0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff <= '0;
         hist0_ff      <= '0;
         hist1_ff      <= '0;
      end else begin
         prev_angle_ff <= prev_angle_in;
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
      end
   end

   a_vel_bound: assert property (@(posedge clock) disable iff (reset)
      advance |-> (vel_w <= BoundV) && (vel_w >= -BoundV))
      else $error("unwrapped velocity out of range");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> (hist1_ff == $past(hist0_ff)) && (prev_angle_ff == $past(angle)))
      else $error("state did not shift on advance");

endmodule

>>> rtl/rotary_angle_rate_tracker.sv
// ----------------------------------------------------------------------------
// rotary_angle_rate_tracker: angle, velocity and acceleration from samples
// Offset-corrects raw angle words and derives unwrapped rate values.
//
//   channel | dir | handshake          | word
//   req_    | in  | req_valid/stall    | raw_angle
//   rsp_    | out | rsp_valid/stall    | angle, velocity, acceleration
//   csr_    | in  | csr_valid/ready    | index, data (mount, user offset)
//
// From request to response: offset adder into the sample register, then
// the rate unit into the response register.
// One word per cycle sustained; the pipeline holds while a response word is
// valid and rsp_stall is high.
// Synchronous reset clears offsets (mount 401), history and valid flags.
// csr_ready is always high; write offsets only while the block is empty.
// ----------------------------------------------------------------------------
module rotary_angle_rate_tracker import rart_pkg::*; #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic      [ANGLE_BITS-1:0] req_raw_angle,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic      [ANGLE_BITS-1:0] rsp_angle,
   output logic signed [ANGLE_BITS:0] rsp_velocity,
   output logic signed [ANGLE_BITS:0] rsp_acceleration,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  csr_index_type              csr_index,
   input  logic      [ANGLE_BITS-1:0] csr_data
);

   localparam logic [ANGLE_BITS-1:0] MountReset = ANGLE_BITS'(MOUNT_OFFSET_RESET);

   logic signed [ANGLE_BITS-1:0] mount_ff, mount_in;
   logic signed [ANGLE_BITS-1:0] user_ff, user_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [ANGLE_BITS-1:0] s1_angle_ff, s1_angle_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic      [ANGLE_BITS-1:0] rsp_angle_ff, rsp_angle_in;
   logic signed [ANGLE_BITS:0] rsp_vel_ff, rsp_vel_in;
   logic signed [ANGLE_BITS:0] rsp_acc_ff, rsp_acc_in;

   logic                       out_free;
   logic                       advance;
   logic                       req_take;
   logic      [ANGLE_BITS-1:0] wrap_angle;
   logic signed [ANGLE_BITS:0] vel_w;
   logic signed [ANGLE_BITS:0] acc_w;

   // ---- configuration ----
   assign csr_ready = 1'b1;

   always_comb begin
      mount_in = mount_ff;
      user_in  = user_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MOUNT_OFFSET: mount_in = $signed(csr_data);
            CSR_USER_OFFSET:  user_in  = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff <= $signed(MountReset);
         user_ff  <= '0;
      end else begin
         mount_ff <= mount_in;
         user_ff  <= user_in;
      end
   end

   // ---- handshake ----
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   rart_wrap #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_wrap (
      .raw_angle    (req_raw_angle),
      .mount_offset (mount_ff),
      .user_offset  (user_ff),
      .angle        (wrap_angle)
   );

   rart_rate #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_rate (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .angle        (s1_angle_ff),
      .velocity     (vel_w),
      .acceleration (acc_w)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_angle_in = s1_angle_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_angle_in = wrap_angle;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_acc_in   = rsp_acc_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_angle_in = s1_angle_ff;
         rsp_vel_in   = vel_w;
         rsp_acc_in   = acc_w;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_angle_ff  <= s1_angle_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angle        = rsp_angle_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_acceleration = rsp_acc_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_angle_ff))
      else $error("sample register lost a word while blocked");

endmodule
